@@ src/assert_macros.svh @@
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/abd_pkg.sv @@
// Shared types, codes and helpers of the articulation bytecode decoder.
`default_nettype none

package abd_pkg;

    localparam int unsigned OUT_TICK_W = 24;
    localparam int unsigned WAIT_W     = 18;
    localparam int unsigned LEVEL_W    = 7;
    localparam int unsigned CENTS_W    = 12;
    localparam int unsigned WAVE_W     = 15;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd127;

    // opcodes (high nibble of an instruction byte)
    localparam logic [3:0] OP_VOLUME    = 4'h0;
    localparam logic [3:0] OP_SKIP_A    = 4'h1;
    localparam logic [3:0] OP_PITCH     = 4'h2;
    localparam logic [3:0] OP_SKIP_B    = 4'h3;
    localparam logic [3:0] OP_SKIP_VAR  = 4'h4;
    localparam logic [3:0] OP_SKIP_C    = 4'h5;
    localparam logic [3:0] OP_WAVE      = 4'h6;
    localparam logic [3:0] OP_END       = 4'h7;
    localparam logic [3:0] OP_NOP       = 4'h8;
    localparam logic [3:0] OP_LOOP      = 4'h9;

    typedef enum logic [3:0] {
        PH_OP,
        PH_EXT1,
        PH_EXT2,
        PH_VOL,
        PH_SKIP1,
        PH_PITCH_HI,
        PH_PITCH_LO,
        PH_SKIP_THEN_VAR,
        PH_VAR1,
        PH_VAR2
    } t_phase;

    typedef enum logic [2:0] {
        K_ENVELOPE,
        K_PITCH,
        K_WAVE,
        K_END,
        K_LOOP_HOLD,
        K_BAD_OP,
        K_TRUNC
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [OUT_TICK_W-1:0]      event_tick;
        logic [LEVEL_W-1:0]         level;
        logic signed [CENTS_W-1:0]  cents;
        logic [WAVE_W-1:0]          wave_index;
        logic                       last_of_run;
    } t_result;

    // all results caused by one byte
    typedef struct packed {
        logic    two;
        t_result first;
        t_result second;
    } t_entry;

    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_status;

    // saturate a running tick to the 24-bit result field
    function automatic logic [OUT_TICK_W-1:0] sat_tick(input logic [32:0] t);
        logic [OUT_TICK_W-1:0] r;
        if (t[32:OUT_TICK_W] != '0) begin
            r = '1;
        end else begin
            r = t[OUT_TICK_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/abd_stream_if.sv @@
// Valid/ready channel interfaces: program bytes in, decoded results out.
`default_nettype none

interface abd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       final_byte;

    modport source (output valid, output code_byte, output final_byte, input ready);
    modport sink   (input valid, input code_byte, input final_byte, output ready);
endinterface

interface abd_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [23:0]        event_tick;
    logic [6:0]         level;
    logic signed [11:0] cents;
    logic [14:0]        wave_index;
    logic               last_of_run;

    modport source (output valid, output kind, output event_tick, output level,
                    output cents, output wave_index, output last_of_run, input ready);
    modport sink   (input valid, input kind, input event_tick, input level,
                    input cents, input wave_index, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ src/abd_front.sv @@
// Front end: accepts program bytes, runs the parser state and forms result entries.
`default_nettype none

module abd_front import abd_pkg::*; #(
    parameter int unsigned TICK_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    abd_byte_if.sink      i_byte,
    input  t_q_status     i_q_status,
    output logic          o_push,
    output t_entry        o_entry
);

    t_phase                    r_phase, n_phase;
    logic [3:0]                r_op, n_op;
    logic [WAIT_W-1:0]         r_wait, n_wait;
    logic [TICK_BITS-1:0]      r_tick, n_tick;
    logic [LEVEL_W-1:0]        r_vol, n_vol;
    logic signed [CENTS_W-1:0] r_pitch, n_pitch;
    logic [7:0]                r_high, n_high;
    logic                      r_stopped, n_stopped;

    logic                      accept;
    logic [7:0]                b;
    logic                      fin;

    logic signed [9:0]         vol_rel;
    logic [LEVEL_W-1:0]        vol_rel_c;
    logic signed [15:0]        pitch_v;
    logic signed [17:0]        pitch_rel;
    logic signed [CENTS_W-1:0] pitch_abs_c;
    logic signed [CENTS_W-1:0] pitch_rel_c;

    logic                      do_disp, do_comp;
    logic                      main_v, fin_v;
    t_kind                     main_kind, fin_kind;
    logic [WAVE_W-1:0]         main_wave;
    logic [TICK_BITS:0]        comp_sum;
    t_result                   main_rec, fin_rec;

    assign b      = i_byte.code_byte;
    assign fin    = i_byte.final_byte;
    assign i_byte.ready = !i_q_status.full;
    assign accept = i_byte.valid && i_byte.ready;

    // relative volume is biased about 192, relative pitch about 2400
    assign vol_rel   = $signed({3'b000, r_vol}) + $signed({2'b00, b}) - 10'sd192;
    assign vol_rel_c = (vol_rel < 10'sd0)   ? '0 :
                       (vol_rel > 10'sd127) ? FULL_LEVEL : vol_rel[LEVEL_W-1:0];

    assign pitch_v     = $signed({r_high, b});
    assign pitch_rel   = $signed({{6{r_pitch[CENTS_W-1]}}, r_pitch})
                       + $signed({{2{pitch_v[15]}}, pitch_v}) - 18'sd2400;
    assign pitch_abs_c = (pitch_v < -16'sd1200) ? -12'sd1200 : pitch_v[CENTS_W-1:0];
    assign pitch_rel_c = (pitch_rel < -18'sd1200) ? -12'sd1200 :
                         (pitch_rel > 18'sd1200)  ? 12'sd1200  : pitch_rel[CENTS_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_op      = r_op;
        n_wait    = r_wait;
        n_tick    = r_tick;
        n_vol     = r_vol;
        n_pitch   = r_pitch;
        n_high    = r_high;
        n_stopped = r_stopped;
        do_disp   = 1'b0;
        do_comp   = 1'b0;
        main_v    = 1'b0;
        main_kind = K_ENVELOPE;
        main_wave = '0;
        fin_v     = 1'b0;
        fin_kind  = K_END;

        if (!r_stopped) begin
            case (r_phase)
                PH_OP: begin
                    n_op   = b[7:4];
                    n_wait = {{(WAIT_W-4){1'b0}}, b[3:0]};
                    if (b[3]) begin
                        n_phase = PH_EXT1;
                    end else begin
                        do_disp = 1'b1;
                    end
                end
                PH_EXT1: begin
                    n_wait = {{(WAIT_W-10){1'b0}}, r_wait[2:0], b[6:0]};
                    if (b[7]) begin
                        n_phase = PH_EXT2;
                    end else begin
                        do_disp = 1'b1;
                    end
                end
                PH_EXT2: begin
                    n_wait  = {r_wait[9:0], b};
                    do_disp = 1'b1;
                end
                PH_VOL: begin
                    n_vol     = b[7] ? vol_rel_c : b[6:0];
                    main_v    = 1'b1;
                    main_kind = K_ENVELOPE;
                    do_comp   = 1'b1;
                end
                PH_SKIP1: begin
                    do_comp = 1'b1;
                end
                PH_PITCH_HI: begin
                    n_high  = b;
                    n_phase = PH_PITCH_LO;
                end
                PH_PITCH_LO: begin
                    n_pitch   = (pitch_v <= 16'sd1200) ? pitch_abs_c : pitch_rel_c;
                    main_v    = 1'b1;
                    main_kind = K_PITCH;
                    do_comp   = 1'b1;
                end
                PH_SKIP_THEN_VAR: begin
                    n_phase = PH_VAR1;
                end
                PH_VAR1: begin
                    if (b[7]) begin
                        n_high  = b;
                        n_phase = PH_VAR2;
                    end else begin
                        main_v    = (r_op == OP_WAVE);
                        main_kind = K_WAVE;
                        main_wave = {{(WAVE_W-7){1'b0}}, b[6:0]};
                        do_comp   = 1'b1;
                    end
                end
                PH_VAR2: begin
                    main_v    = (r_op == OP_WAVE);
                    main_kind = K_WAVE;
                    main_wave = {r_high[6:0], b};
                    do_comp   = 1'b1;
                end
                default: begin
                    n_phase = PH_OP;
                end
            endcase
        end

        // wait fully read: act on the opcode
        if (do_disp) begin
            case (n_op)
                OP_VOLUME:                      n_phase = PH_VOL;
                OP_SKIP_A, OP_SKIP_B, OP_SKIP_C: n_phase = PH_SKIP1;
                OP_PITCH:                       n_phase = PH_PITCH_HI;
                OP_SKIP_VAR:                    n_phase = PH_SKIP_THEN_VAR;
                OP_WAVE:                        n_phase = PH_VAR1;
                OP_END: begin
                    main_v    = 1'b1;
                    main_kind = K_END;
                    n_stopped = 1'b1;
                end
                OP_NOP: do_comp = 1'b1;
                OP_LOOP: begin
                    main_v    = 1'b1;
                    main_kind = K_LOOP_HOLD;
                    n_stopped = 1'b1;
                end
                default: begin
                    main_v    = 1'b1;
                    main_kind = K_BAD_OP;
                    n_stopped = 1'b1;
                end
            endcase
        end

        // instruction done: advance the tick by its wait, saturating
        comp_sum = {1'b0, r_tick} + (TICK_BITS+1)'(n_wait);
        if (do_comp) begin
            n_tick  = comp_sum[TICK_BITS] ? '1 : comp_sum[TICK_BITS-1:0];
            n_wait  = '0;
            n_phase = PH_OP;
        end

        main_rec.kind        = main_kind;
        main_rec.event_tick  = sat_tick(33'(r_tick));
        main_rec.level       = n_vol;
        main_rec.cents       = n_pitch;
        main_rec.wave_index  = main_wave;
        main_rec.last_of_run = 1'b1;

        if (fin && !n_stopped) begin
            fin_v    = 1'b1;
            fin_kind = (n_phase == PH_OP) ? K_END : K_TRUNC;
        end

        fin_rec.kind        = fin_kind;
        fin_rec.event_tick  = sat_tick(33'(n_tick));
        fin_rec.level       = n_vol;
        fin_rec.cents       = n_pitch;
        fin_rec.wave_index  = '0;
        fin_rec.last_of_run = 1'b1;

        // end of program entry: re-arm for the next program
        if (fin) begin
            n_phase   = PH_OP;
            n_op      = '0;
            n_wait    = '0;
            n_tick    = '0;
            n_vol     = FULL_LEVEL;
            n_pitch   = '0;
            n_high    = '0;
            n_stopped = 1'b0;
        end

        o_entry.two                = main_v && fin_v;
        o_entry.first              = main_v ? main_rec : fin_rec;
        o_entry.first.last_of_run  = !(main_v && fin_v);
        o_entry.second             = fin_rec;
        o_push                     = accept && (main_v || fin_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_OP;
            r_op      <= '0;
            r_wait    <= '0;
            r_tick    <= '0;
            r_vol     <= FULL_LEVEL;
            r_pitch   <= '0;
            r_high    <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_op      <= n_op;
            r_wait    <= n_wait;
            r_tick    <= n_tick;
            r_vol     <= n_vol;
            r_pitch   <= n_pitch;
            r_high    <= n_high;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

@@ src/abd_queue.sv @@
// Short entry queue between the parser front end and the result back end.
`default_nettype none

module abd_queue import abd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_q_status o_status,
    output t_entry    o_head
);

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_status.head_valid = (r_count != '0);
    assign o_status.full       = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_head              = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/abd_back.sv @@
// Back end: plays out the queued results one transaction at a time via an output register.
`default_nettype none

module abd_back import abd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_q_status     i_q_status,
    input  t_entry        i_head,
    output logic          o_pop,
    abd_result_if.source  o_result
);

    logic    r_sel;       // 1: the second result of the head entry is next
    logic    r_valid;
    t_result r_out;
    logic    load;
    logic    last_pick;

    assign load      = i_q_status.head_valid && (!r_valid || o_result.ready);
    assign last_pick = r_sel || !i_head.two;
    assign o_pop     = load && last_pick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= !last_pick;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= r_sel ? i_head.second : i_head.first;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.kind        = r_out.kind;
    assign o_result.event_tick  = r_out.event_tick;
    assign o_result.level       = r_out.level;
    assign o_result.cents       = r_out.cents;
    assign o_result.wave_index  = r_out.wave_index;
    assign o_result.last_of_run = r_out.last_of_run;

endmodule

`default_nettype wire

@@ src/articulation_bytecode_decoder_core.sv @@
// A byte's first result is written into the queue and then loaded into the output register.
// Throughput: one byte per cycle; one result per cycle out while the sink is ready, so a byte with two results
//   (an event plus end of program) is sent as two results, absorbed by a 4-entry queue.
// Input stalls only when the queue is full; the parse state updates in the accept cycle.
// Reset: synchronous, active low; parser re-armed (tick 0, volume 127, pitch 0), queue
//   and output register emptied.
`default_nettype none

`include "assert_macros.svh"

module articulation_bytecode_decoder_core import abd_pkg::*; #(
    parameter int unsigned TICK_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    abd_byte_if.sink      i_byte,
    abd_result_if.source  o_result
);

    // Front/back split: the front decodes each byte in its accept cycle and pushes the
    // results it caused as one queue entry; the back drains entries, one result per
    // transaction. Bytes that cause no result never touch the queue.
    logic      push;
    logic      pop;
    t_entry    push_entry;
    t_entry    head_entry;
    t_q_status q_status;

    abd_front #(
        .TICK_BITS (TICK_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (i_byte),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    abd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_status (q_status),
        .o_head   (head_entry)
    );

    abd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head     (head_entry),
        .o_pop      (pop),
        .o_result   (o_result)
    );

    // never push into a full queue
    `ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, push, !q_status.full)
    // never pop an empty queue
    `ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, pop, q_status.head_valid)
    // a result that is not last of its run is followed right away by the rest
    `ASSERT_NEXT(a_run_continues, i_clk, i_rst_n,
        o_result.valid && o_result.ready && !o_result.last_of_run, o_result.valid)
    // a popped two-result entry has its first result marked as not last of its run
    `ASSERT_IMPL(a_pair_kept, i_clk, i_rst_n,
        pop && head_entry.two, !head_entry.first.last_of_run)

endmodule

`default_nettype wire
